### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EWCM_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define EWCM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/ewcm_pkg.sv
package ewcm_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int FRACTION_BITS = 16;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int OFS_W   = 15;
    localparam int MAG_W   = 13;
    localparam int PROD_W  = 25;
    localparam int QUO_W   = FRACTION_BITS + 1;
    localparam int RAD_W   = 2 * FRACTION_BITS + 2;
    localparam int ROOT_W  = FRACTION_BITS + 1;
    localparam int TERM_W  = ROOT_W + 1 + OFS_W;
    localparam int SUM_W   = TERM_W + 1;
    localparam int SX_W    = SUM_W - FRACTION_BITS - 1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] source_x;
        logic [COORD_W-1:0] source_y;
        logic               inside_res;
    } out_t;

    typedef struct packed {
        logic                    zero;
        logic signed [OFS_W-1:0] dx2;
        logic signed [OFS_W-1:0] dy2;
    } side_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        if (d > DIM_W'(MAX_DIMENSION))
            return DIM_W'(MAX_DIMENSION);
        return d;
    endfunction

endpackage

### hdl/ewcm_front.sv
module ewcm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  ewcm_pkg::in_t              in_data,
    input  logic [ewcm_pkg::DIM_W-1:0] width,
    input  logic [ewcm_pkg::DIM_W-1:0] height,
    output logic                       out_valid,
    output logic [ewcm_pkg::PROD_W-1:0] out_mx,
    output logic [ewcm_pkg::PROD_W-1:0] out_mn,
    output ewcm_pkg::side_t            out_side
);
    import ewcm_pkg::*;

    logic [DIM_W-1:0]  w_c;
    logic [DIM_W-1:0]  h_c;
    side_t             a_side_next;
    logic [MAG_W-1:0]  a_ax_next;
    logic [MAG_W-1:0]  a_ay_next;
    logic [OFS_W-1:0]  neg_x;
    logic [OFS_W-1:0]  neg_y;

    logic              a_vld_reg;
    side_t             a_side_reg;
    logic [MAG_W-1:0]  a_ax_reg;
    logic [MAG_W-1:0]  a_ay_reg;

    logic [2*MAG_W-1:0] u_full;
    logic [2*MAG_W-1:0] v_full;
    logic              b_vld_reg;
    side_t             b_side_reg;
    logic [PROD_W-1:0] b_u_reg;
    logic [PROD_W-1:0] b_v_reg;

    logic [PROD_W-1:0] c_mx_next;
    logic [PROD_W-1:0] c_mn_next;
    logic              c_vld_reg;
    side_t             c_side_reg;
    logic [PROD_W-1:0] c_mx_reg;
    logic [PROD_W-1:0] c_mn_reg;

    always_comb
    begin
        w_c = clamp_dim(width);
        h_c = clamp_dim(height);
        a_side_next.zero = (w_c == '0) || (h_c == '0);
        a_side_next.dx2  = $signed({2'b00, in_data.dest_x, 1'b0}) - $signed({2'b00, w_c});
        a_side_next.dy2  = $signed({2'b00, in_data.dest_y, 1'b0}) - $signed({2'b00, h_c});
        neg_x = -a_side_next.dx2;
        neg_y = -a_side_next.dy2;
        a_ax_next = a_side_next.dx2[OFS_W-1] ? neg_x[MAG_W-1:0] : a_side_next.dx2[MAG_W-1:0];
        a_ay_next = a_side_next.dy2[OFS_W-1] ? neg_y[MAG_W-1:0] : a_side_next.dy2[MAG_W-1:0];
    end

    assign u_full = h_c * a_ax_reg;
    assign v_full = w_c * a_ay_reg;

    always_comb
    begin
        if (b_u_reg > b_v_reg)
        begin
            c_mx_next = b_u_reg;
            c_mn_next = b_v_reg;
        end
        else
        begin
            c_mx_next = b_v_reg;
            c_mn_next = b_u_reg;
        end
        // centre: divide by one so the quotient stays zero
        if (c_mx_next == '0)
            c_mx_next = PROD_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= a_side_next;
            a_ax_reg   <= a_ax_next;
            a_ay_reg   <= a_ay_next;
            b_side_reg <= a_side_reg;
            b_u_reg    <= u_full[PROD_W-1:0];
            b_v_reg    <= v_full[PROD_W-1:0];
            c_side_reg <= b_side_reg;
            c_mx_reg   <= c_mx_next;
            c_mn_reg   <= c_mn_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_mx    = c_mx_reg;
    assign out_mn    = c_mn_reg;
    assign out_side  = c_side_reg;

endmodule

### hdl/ewcm_div.sv
module ewcm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ewcm_pkg::PROD_W-1:0] mx,
    input  logic [ewcm_pkg::PROD_W-1:0] mn,
    input  ewcm_pkg::side_t             side,
    output logic                        out_valid,
    output logic [ewcm_pkg::QUO_W-1:0]  quo,
    output ewcm_pkg::side_t             out_side
);
    import ewcm_pkg::*;

    logic [PROD_W-1:0] rem_reg  [QUO_W];
    logic [PROD_W-1:0] mx_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    side_t             side_reg [QUO_W];
    logic [QUO_W-1:0]  vld_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [PROD_W-1:0] rem_prev;
        logic [PROD_W-1:0] mx_prev;
        logic [QUO_W-1:0]  quo_prev;
        side_t             side_prev;
        logic              vld_prev;
        logic [PROD_W:0]   trial;
        logic [PROD_W:0]   diff;
        logic              take;
        logic [PROD_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = mn;
            assign mx_prev   = mx;
            assign quo_prev  = '0;
            assign side_prev = side;
            assign vld_prev  = in_valid;
            assign trial     = {1'b0, rem_prev};
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign mx_prev   = mx_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
            assign trial     = {rem_prev, 1'b0};
        end

        assign take     = trial >= {1'b0, mx_prev};
        assign diff     = trial - {1'b0, mx_prev};
        assign rem_next = take ? diff[PROD_W-1:0] : trial[PROD_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                mx_reg[k]   <= mx_prev;
                quo_reg[k]  <= {quo_prev[QUO_W-2:0], take};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

### hdl/ewcm_sqrt.sv
module ewcm_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ewcm_pkg::QUO_W-1:0]  quo,
    input  ewcm_pkg::side_t             side,
    output logic                        out_valid,
    output logic [ewcm_pkg::ROOT_W-1:0] root,
    output ewcm_pkg::side_t             out_side
);
    import ewcm_pkg::*;

    localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * FRACTION_BITS);

    logic [2*QUO_W-1:0] sq_full;
    logic [RAD_W-1:0]   n_reg;
    logic               n_vld_reg;
    side_t              n_side_reg;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    assign sq_full = quo * quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else if (en)
            n_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg      <= ONE_SQ + RAD_W'(sq_full);
            n_side_reg <= side;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam int BIT = ROOT_W - 1 - k;

        logic [RAD_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        side_t             side_prev;
        logic              vld_prev;
        logic [RAD_W:0]    trial;
        logic [RAD_W:0]    left;
        logic              take;

        if (k == 0)
        begin : g_first
            assign rem_prev  = n_reg;
            assign root_prev = '0;
            assign side_prev = n_side_reg;
            assign vld_prev  = n_vld_reg;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        assign trial = ((RAD_W + 1)'(root_prev) << (BIT + 1)) + ((RAD_W + 1)'(1) << (2 * BIT));
        assign take  = {1'b0, rem_prev} >= trial;
        assign left  = {1'b0, rem_prev} - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? left[RAD_W-1:0] : rem_prev;
                root_reg[k] <= take ? (root_prev | (ROOT_W'(1) << BIT)) : root_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

### hdl/ewcm_back.sv
module ewcm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ewcm_pkg::ROOT_W-1:0] root,
    input  ewcm_pkg::side_t             side,
    input  logic [ewcm_pkg::DIM_W-1:0]  width,
    input  logic [ewcm_pkg::DIM_W-1:0]  height,
    output logic                        out_valid,
    output ewcm_pkg::out_t              out_data
);
    import ewcm_pkg::*;

    logic signed [TERM_W-1:0] px_next;
    logic signed [TERM_W-1:0] py_next;
    logic                     m_vld_reg;
    logic                     m_zero_reg;
    logic signed [TERM_W-1:0] m_px_reg;
    logic signed [TERM_W-1:0] m_py_reg;

    logic [DIM_W-1:0]         w_c;
    logic [DIM_W-1:0]         h_c;
    logic signed [SUM_W-1:0]  nx;
    logic signed [SUM_W-1:0]  ny;
    logic [SUM_W-1:0]         mag_x;
    logic [SUM_W-1:0]         mag_y;
    logic [SX_W-1:0]          sx;
    logic [SX_W-1:0]          sy;
    logic                     in_x;
    logic                     in_y;
    out_t                     out_next;

    logic                     o_vld_reg;
    out_t                     o_data_reg;

    assign px_next = $signed({1'b0, root}) * side.dx2;
    assign py_next = $signed({1'b0, root}) * side.dy2;

    always_comb
    begin
        w_c   = clamp_dim(width);
        h_c   = clamp_dim(height);
        nx    = $signed({{(SUM_W-DIM_W-FRACTION_BITS){1'b0}}, w_c, {FRACTION_BITS{1'b0}}})
                + SUM_W'(m_px_reg);
        ny    = $signed({{(SUM_W-DIM_W-FRACTION_BITS){1'b0}}, h_c, {FRACTION_BITS{1'b0}}})
                + SUM_W'(m_py_reg);
        mag_x = nx[SUM_W-1] ? -nx : nx;
        mag_y = ny[SUM_W-1] ? -ny : ny;
        sx    = mag_x[SUM_W-1:FRACTION_BITS+1];
        sy    = mag_y[SUM_W-1:FRACTION_BITS+1];
        // negative sums land inside only when they truncate to zero
        in_x  = (sx < SX_W'(w_c)) && (!nx[SUM_W-1] || (sx == '0));
        in_y  = (sy < SX_W'(h_c)) && (!ny[SUM_W-1] || (sy == '0));
        out_next.inside_res = in_x && in_y && !m_zero_reg;
        out_next.source_x   = out_next.inside_res ? sx[COORD_W-1:0] : '0;
        out_next.source_y   = out_next.inside_res ? sy[COORD_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= in_valid;
            o_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_zero_reg <= side.zero;
            m_px_reg   <= px_next;
            m_py_reg   <= py_next;
            o_data_reg <= out_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_data  = o_data_reg;

endmodule

### hdl/ellipse_warp_coordinate_map_core.sv
// Path: an accepted input beat passes through the front, divide, square and root,
// and back-end multiply and range stages to its output beat.
// Throughput: one beat per cycle; the whole pipeline holds while out_valid waits.
// Reset: pipeline valid bits clear; image_width returns to 640, image_height to 480.
`include "assert_macros.svh"

module ellipse_warp_coordinate_map_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ewcm_pkg::in_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ewcm_pkg::out_t             out_data,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [ewcm_pkg::DIM_W-1:0] cfg_data
);
    import ewcm_pkg::*;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  width_c;
    logic [DIM_W-1:0]  height_c;
    logic              en;

    logic              f_valid;
    logic [PROD_W-1:0] f_mx;
    logic [PROD_W-1:0] f_mn;
    side_t             f_side;
    logic              d_valid;
    logic [QUO_W-1:0]  d_quo;
    side_t             d_side;
    logic              s_valid;
    logic [ROOT_W-1:0] s_root;
    side_t             s_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    assign width_c  = clamp_dim(width_reg);
    assign height_c = clamp_dim(height_reg);

    // advance everything unless a finished beat is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    ewcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .width     (width_reg),
        .height    (height_reg),
        .out_valid (f_valid),
        .out_mx    (f_mx),
        .out_mn    (f_mn),
        .out_side  (f_side)
    );

    ewcm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .mx        (f_mx),
        .mn        (f_mn),
        .side      (f_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .out_side  (d_side)
    );

    ewcm_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .quo       (d_quo),
        .side      (d_side),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    ewcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .root      (s_root),
        .side      (s_side),
        .width     (width_reg),
        .height    (height_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `EWCM_ASSERT_IMPLY(a_outside_zero, out_valid && !out_data.inside_res,
        out_data.source_x == '0 && out_data.source_y == '0)
    `EWCM_ASSERT_IMPLY(a_inside_x, out_valid && out_data.inside_res,
        {1'b0, out_data.source_x} < width_c)
    `EWCM_ASSERT_IMPLY(a_inside_y, out_valid && out_data.inside_res,
        {1'b0, out_data.source_y} < height_c)

endmodule
